FILE: rtl/mtu_pkg.sv
// ----------------------------------------------------------------------------
// mtu_pkg
// Shared types, constants and index tables of the matrix transform unit.
// ----------------------------------------------------------------------------
package mtu_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [3:0] idx_t;

	localparam word_t Q_ONE = word_t'(64'd1 << FRAC_BITS);
	localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_SAT      = 2'd2;

	// request kinds
	typedef enum logic [2:0] {
		K_WR_CUR  = 3'd0,
		K_WR_STG  = 3'd1,
		K_COMPOSE = 3'd2,
		K_SCALE   = 3'd3,
		K_XFORM   = 3'd4,
		K_NORMAL  = 3'd5
	} kind_t;

	// datapath micro-operations
	typedef enum logic [3:0] {
		U_NOP, U_FETCH, U_MUL, U_RND, U_LD, U_LDA, U_ADD, U_SUB,
		U_WR_CUR, U_WR_STG, U_WR_NM, U_WR_RES, U_SET_D, U_DIV_GO, U_SET_REC, U_DONE
	} uop_t;

	// operand sources
	typedef enum logic [3:0] {
		SRC_CUR, SRC_STG, SRC_NM, SRC_VEC, SRC_VAL, SRC_P, SRC_ACC, SRC_REC,
		SRC_ZERO, SRC_ONE
	} src_t;

	typedef struct packed {
		logic load;
		uop_t uop;
		src_t a_src;
		idx_t a_idx;
		src_t b_src;
		idx_t b_idx;
		idx_t w_idx;
	} cmd_t;

	typedef struct packed {
		logic d_zero;
		logic div_busy;
	} sts_t;

	// determinant terms a*b*c of the upper-left 3x3
	localparam idx_t DET_A [6] = '{4'd0, 4'd4, 4'd8, 4'd2, 4'd6, 4'd10};
	localparam idx_t DET_B [6] = '{4'd5, 4'd9, 4'd1, 4'd5, 4'd9, 4'd1};
	localparam idx_t DET_C [6] = '{4'd10, 4'd2, 4'd6, 4'd8, 4'd0, 4'd4};

	// cofactors a*b - c*d and where they land
	localparam idx_t COF_A [9] = '{4'd5, 4'd8, 4'd4, 4'd9, 4'd0, 4'd8, 4'd1, 4'd4, 4'd0};
	localparam idx_t COF_B [9] = '{4'd10, 4'd6, 4'd9, 4'd2, 4'd10, 4'd1, 4'd6, 4'd2, 4'd5};
	localparam idx_t COF_C [9] = '{4'd9, 4'd4, 4'd8, 4'd1, 4'd8, 4'd0, 4'd5, 4'd0, 4'd4};
	localparam idx_t COF_D [9] = '{4'd6, 4'd10, 4'd5, 4'd10, 4'd2, 4'd9, 4'd2, 4'd6, 4'd1};
	localparam idx_t COF_DST [9] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10};

endpackage

FILE: rtl/mtu_div.sv
// ----------------------------------------------------------------------------
// mtu_div
// Restoring divider, one quotient bit per cycle, for the reciprocal of the
// determinant: 2^(2*FRAC_BITS) / divisor.
// ----------------------------------------------------------------------------
module mtu_div import mtu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 busy,
	output logic [WORD_BITS:0]   quot
);

	localparam int QBITS = WORD_BITS + 1;
	localparam logic [WORD_BITS:0] DIV_NUM = (WORD_BITS+1)'(1) << (2*FRAC_BITS);

	logic [5:0]           cnt_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS:0]   quo_q;
	logic [WORD_BITS-1:0] div_q;
	logic [WORD_BITS:0]   shifted;
	logic                 take;

	// trial subtract
	assign shifted = {rem_q, quo_q[WORD_BITS]};
	assign take    = shifted >= {1'b0, div_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(QBITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= DIV_NUM;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= take ? WORD_BITS'(shifted - {1'b0, div_q}) : shifted[WORD_BITS-1:0];
			quo_q <= {quo_q[WORD_BITS-1:0], take};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;

endmodule

FILE: rtl/mtu_datapath.sv
// ----------------------------------------------------------------------------
// mtu_datapath
// Matrix stores, operand registers, shared multiplier, saturating
// accumulator, reciprocal divider and result registers.
// ----------------------------------------------------------------------------
module mtu_datapath import mtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  word_t      value,
	input  word_t      vec_x,
	input  word_t      vec_y,
	input  word_t      vec_z,
	input  word_t      vec_w,
	output sts_t       sts,
	output word_t      out_x,
	output word_t      out_y,
	output word_t      out_z,
	output word_t      out_w,
	output word_t      determinant,
	output logic [1:0] status,
	output logic       done
);

	typedef struct packed {
		word_t v;
		logic  f;
	} sat_t;

	word_t       cur_mem_q [16];
	word_t       stg_mem_q [16];
	word_t       nm_mem_q  [16];
	logic [15:0] cur_vld_q;
	logic [15:0] stg_vld_q;
	word_t       val_q;
	word_t       vec_q [4];
	word_t       res_q [4];
	word_t       opa_q, opb_q, p_q, acc_q, d_q, rec_q;
	logic signed [2*WORD_BITS-1:0] prod_q;
	logic        f_q, sing_q, done_q;
	word_t       ox_q, oy_q, oz_q, ow_q, det_q;
	logic [1:0]  st_q;

	logic                 div_busy;
	logic [WORD_BITS:0]   quot;
	logic [WORD_BITS-1:0] d_mag;
	sat_t                 rnd_r, add_r, rec_r;

	// operand read
	function automatic word_t rd(src_t s, idx_t i);
		word_t r;
		case (s)
			SRC_CUR:  r = cur_vld_q[i] ? cur_mem_q[i] : ((i[1:0] == i[3:2]) ? Q_ONE : '0);
			SRC_STG:  r = stg_vld_q[i] ? stg_mem_q[i] : '0;
			SRC_NM:   r = nm_mem_q[i];
			SRC_VEC:  r = vec_q[i[1:0]];
			SRC_VAL:  r = val_q;
			SRC_P:    r = p_q;
			SRC_ACC:  r = acc_q;
			SRC_REC:  r = rec_q;
			SRC_ONE:  r = Q_ONE;
			default:  r = '0;
		endcase
		return r;
	endfunction

	// product shift toward zero and saturate
	always_comb begin
		logic [2*WORD_BITS-1:0]         m64;
		logic [2*WORD_BITS-1-FRAC_BITS:0] m;
		m64 = prod_q[2*WORD_BITS-1] ? (2*WORD_BITS)'(-prod_q) : prod_q;
		m   = m64[2*WORD_BITS-1:FRAC_BITS];
		rnd_r.f = 1'b0;
		if (!prod_q[2*WORD_BITS-1]) begin
			if (m > (2*WORD_BITS-FRAC_BITS)'(W_MAX)) begin
				rnd_r.v = W_MAX;
				rnd_r.f = 1'b1;
			end else begin
				rnd_r.v = word_t'(m);
			end
		end else begin
			if (m > (2*WORD_BITS-FRAC_BITS)'({1'b0, W_MIN})) begin
				rnd_r.v = W_MIN;
				rnd_r.f = 1'b1;
			end else begin
				rnd_r.v = word_t'(-m[WORD_BITS-1:0]);
			end
		end
	end

	// saturating accumulate
	always_comb begin
		logic signed [WORD_BITS:0] s;
		if (cmd.uop == U_SUB) begin
			s = {acc_q[WORD_BITS-1], acc_q} - {p_q[WORD_BITS-1], p_q};
		end else begin
			s = {acc_q[WORD_BITS-1], acc_q} + {p_q[WORD_BITS-1], p_q};
		end
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			add_r.v = s[WORD_BITS] ? W_MIN : W_MAX;
			add_r.f = 1'b1;
		end else begin
			add_r.v = s[WORD_BITS-1:0];
			add_r.f = 1'b0;
		end
	end

	// signed reciprocal from quotient
	always_comb begin
		rec_r.f = 1'b0;
		if (!d_q[WORD_BITS-1]) begin
			if (quot > (WORD_BITS+1)'(W_MAX)) begin
				rec_r.v = W_MAX;
				rec_r.f = 1'b1;
			end else begin
				rec_r.v = quot[WORD_BITS-1:0];
			end
		end else begin
			if (quot > (WORD_BITS+1)'({1'b0, W_MIN})) begin
				rec_r.v = W_MIN;
				rec_r.f = 1'b1;
			end else begin
				rec_r.v = word_t'(-quot[WORD_BITS-1:0]);
			end
		end
	end

	assign d_mag = d_q[WORD_BITS-1] ? (~d_q + 1'b1) : d_q;

	mtu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.uop == U_DIV_GO),
		.divisor (d_mag),
		.busy    (div_busy),
		.quot    (quot)
	);

	// valid bits, flags and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= '0;
			stg_vld_q <= '0;
			f_q       <= 1'b0;
			sing_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.uop == U_DONE;
			if (cmd.uop == U_WR_CUR) cur_vld_q[cmd.w_idx] <= 1'b1;
			if (cmd.uop == U_WR_STG) stg_vld_q[cmd.w_idx] <= 1'b1;
			if (cmd.load) begin
				f_q    <= 1'b0;
				sing_q <= 1'b0;
			end else begin
				if ((cmd.uop == U_RND && rnd_r.f) ||
				    ((cmd.uop == U_ADD || cmd.uop == U_SUB) && add_r.f) ||
				    (cmd.uop == U_SET_REC && rec_r.f)) begin
					f_q <= 1'b1;
				end
				if (cmd.uop == U_SET_D && acc_q == '0) sing_q <= 1'b1;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q    <= value;
			vec_q[0] <= vec_x;
			vec_q[1] <= vec_y;
			vec_q[2] <= vec_z;
			vec_q[3] <= vec_w;
		end
	end

	// micro-operation execution
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int n = 0; n < 4; n++) res_q[n] <= '0;
		end
		case (cmd.uop)
			U_FETCH: begin
				opa_q <= rd(cmd.a_src, cmd.a_idx);
				opb_q <= rd(cmd.b_src, cmd.b_idx);
			end
			U_MUL:     prod_q <= opa_q * opb_q;
			U_RND:     p_q <= rnd_r.v;
			U_LD:      acc_q <= p_q;
			U_LDA:     acc_q <= opa_q;
			U_ADD,
			U_SUB:     acc_q <= add_r.v;
			U_WR_CUR:  cur_mem_q[cmd.w_idx] <= acc_q;
			U_WR_STG:  stg_mem_q[cmd.w_idx] <= acc_q;
			U_WR_NM:   nm_mem_q[cmd.w_idx] <= acc_q;
			U_WR_RES:  res_q[cmd.w_idx[1:0]] <= acc_q;
			U_SET_D:   d_q <= acc_q;
			U_SET_REC: rec_q <= rec_r.v;
			U_DONE: begin
				ox_q  <= res_q[0];
				oy_q  <= res_q[1];
				oz_q  <= res_q[2];
				ow_q  <= res_q[3];
				det_q <= acc_q;
				st_q  <= sing_q ? ST_SINGULAR : (f_q ? ST_SAT : ST_OK);
			end
			default: ;
		endcase
	end

	assign sts.d_zero   = d_q == '0;
	assign sts.div_busy = div_busy;

	assign out_x       = ox_q;
	assign out_y       = oy_q;
	assign out_z       = oz_q;
	assign out_w       = ow_q;
	assign determinant = det_q;
	assign status      = st_q;
	assign done        = done_q;

endmodule

FILE: rtl/mtu_ctrl.sv
// ----------------------------------------------------------------------------
// mtu_ctrl
// Sequencer: walks each request through its micro-operations and issues
// one registered command per cycle to the datapath.
// ----------------------------------------------------------------------------
module mtu_ctrl import mtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] kind,
	input  idx_t       element_index,
	input  sts_t       sts,
	output logic       busy,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_WRITE, S_COMP, S_COPY, S_SCALE, S_XFORM, S_DET, S_SETD,
		S_DWAIT, S_DCHK, S_DIVW1, S_DIVW, S_COF, S_DONE
	} state_t;

	state_t     state_q;
	logic       busy_q;
	cmd_t       cmd_q;
	logic [3:0] i_q;
	logic [1:0] k_q;
	logic [3:0] ph_q;
	logic       final_q;
	kind_t      kind_q;
	idx_t       idx_q;

	function automatic cmd_t mk(uop_t u, src_t as, idx_t ai, src_t bs, idx_t bi, idx_t wi);
		cmd_t c;
		c.load  = 1'b0;
		c.uop   = u;
		c.a_src = as;
		c.a_idx = ai;
		c.b_src = bs;
		c.b_idx = bi;
		c.w_idx = wi;
		return c;
	endfunction

	function automatic cmd_t op(uop_t u);
		return mk(u, SRC_ZERO, '0, SRC_ZERO, '0, '0);
	endfunction

	// copy source: normal matrix fills the border with zeros and a one
	function automatic src_t copy_src(kind_t k, logic [3:0] i);
		src_t s;
		if (k != K_NORMAL) s = SRC_NM;
		else if (i[1:0] != 2'd3 && i[3:2] != 2'd3) s = SRC_NM;
		else if (i == 4'd15) s = SRC_ONE;
		else s = SRC_ZERO;
		return s;
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			cmd_q   <= op(U_NOP);
			i_q     <= '0;
			k_q     <= '0;
			ph_q    <= '0;
			final_q <= 1'b0;
			kind_q  <= K_WR_CUR;
			idx_q   <= '0;
		end else begin
			cmd_q <= op(U_NOP);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						idx_q   <= element_index;
						i_q     <= '0;
						k_q     <= '0;
						ph_q    <= '0;
						final_q <= 1'b1;
						unique case (kind)
							K_WR_CUR:  begin kind_q <= K_WR_CUR;  state_q <= S_WRITE; end
							K_WR_STG:  begin kind_q <= K_WR_STG;  state_q <= S_WRITE; end
							K_COMPOSE: begin kind_q <= K_COMPOSE; state_q <= S_COMP;  end
							K_SCALE:   begin kind_q <= K_SCALE;   state_q <= S_SCALE; end
							K_XFORM:   begin kind_q <= K_XFORM;   state_q <= S_XFORM; end
							K_NORMAL: begin
								kind_q  <= K_NORMAL;
								final_q <= 1'b0;
								state_q <= S_DET;
							end
							default: begin kind_q <= K_COMPOSE; state_q <= S_DET; end
						endcase
					end
				end

				// element write
				S_WRITE: begin
					case (ph_q)
						4'd0: begin
							cmd_q <= mk(U_FETCH, SRC_VAL, '0, SRC_ZERO, '0, '0);
							ph_q  <= 4'd1;
						end
						4'd1: begin
							cmd_q <= op(U_LDA);
							ph_q  <= 4'd2;
						end
						default: begin
							cmd_q <= mk((kind_q == K_WR_STG) ? U_WR_STG : U_WR_CUR,
							            SRC_ZERO, '0, SRC_ZERO, '0, idx_q);
							ph_q  <= '0;
							i_q   <= '0;
							state_q <= S_DET;
						end
					endcase
				end

				// compose: row of current times column of staged
				S_COMP: begin
					case (ph_q)
						4'd0: begin
							cmd_q <= mk(U_FETCH, SRC_CUR, {i_q[3:2], k_q},
							            SRC_STG, {k_q, i_q[1:0]}, '0);
							ph_q  <= 4'd1;
						end
						4'd1: begin cmd_q <= op(U_MUL); ph_q <= 4'd2; end
						4'd2: begin cmd_q <= op(U_RND); ph_q <= 4'd3; end
						4'd3: begin
							cmd_q <= op((k_q == 2'd0) ? U_LD : U_ADD);
							if (k_q == 2'd3) begin
								ph_q <= 4'd4;
							end else begin
								k_q  <= k_q + 2'd1;
								ph_q <= '0;
							end
						end
						default: begin
							cmd_q <= mk(U_WR_NM, SRC_ZERO, '0, SRC_ZERO, '0, i_q);
							k_q   <= '0;
							ph_q  <= '0;
							if (i_q == 4'd15) begin
								i_q     <= '0;
								state_q <= S_COPY;
							end else begin
								i_q <= i_q + 4'd1;
							end
						end
					endcase
				end

				// sweep the new matrix into current
				S_COPY: begin
					case (ph_q)
						4'd0: begin
							cmd_q <= mk(U_FETCH, copy_src(kind_q, i_q), i_q, SRC_ZERO, '0, '0);
							ph_q  <= 4'd1;
						end
						4'd1: begin cmd_q <= op(U_LDA); ph_q <= 4'd2; end
						default: begin
							cmd_q <= mk(U_WR_CUR, SRC_ZERO, '0, SRC_ZERO, '0, i_q);
							ph_q  <= '0;
							if (i_q == 4'd15) begin
								i_q     <= '0;
								final_q <= 1'b1;
								state_q <= S_DET;
							end else begin
								i_q <= i_q + 4'd1;
							end
						end
					endcase
				end

				// elementwise scale in place
				S_SCALE: begin
					case (ph_q)
						4'd0: begin
							cmd_q <= mk(U_FETCH, SRC_CUR, i_q, SRC_VAL, '0, '0);
							ph_q  <= 4'd1;
						end
						4'd1: begin cmd_q <= op(U_MUL); ph_q <= 4'd2; end
						4'd2: begin cmd_q <= op(U_RND); ph_q <= 4'd3; end
						4'd3: begin cmd_q <= op(U_LD);  ph_q <= 4'd4; end
						default: begin
							cmd_q <= mk(U_WR_CUR, SRC_ZERO, '0, SRC_ZERO, '0, i_q);
							ph_q  <= '0;
							if (i_q == 4'd15) begin
								i_q     <= '0;
								state_q <= S_DET;
							end else begin
								i_q <= i_q + 4'd1;
							end
						end
					endcase
				end

				// vector transform, one row at a time
				S_XFORM: begin
					case (ph_q)
						4'd0: begin
							cmd_q <= mk(U_FETCH, SRC_CUR, {i_q[1:0], k_q},
							            SRC_VEC, {2'b00, k_q}, '0);
							ph_q  <= 4'd1;
						end
						4'd1: begin cmd_q <= op(U_MUL); ph_q <= 4'd2; end
						4'd2: begin cmd_q <= op(U_RND); ph_q <= 4'd3; end
						4'd3: begin
							cmd_q <= op((k_q == 2'd0) ? U_LD : U_ADD);
							if (k_q == 2'd3) begin
								ph_q <= 4'd4;
							end else begin
								k_q  <= k_q + 2'd1;
								ph_q <= '0;
							end
						end
						default: begin
							cmd_q <= mk(U_WR_RES, SRC_ZERO, '0, SRC_ZERO, '0, {2'b00, i_q[1:0]});
							k_q   <= '0;
							ph_q  <= '0;
							if (i_q[1:0] == 2'd3) begin
								i_q     <= '0;
								state_q <= S_DET;
							end else begin
								i_q <= i_q + 4'd1;
							end
						end
					endcase
				end

				// 3x3 determinant: six triple products
				S_DET: begin
					case (ph_q)
						4'd0: begin
							cmd_q <= mk(U_FETCH, SRC_CUR, DET_A[i_q[2:0]],
							            SRC_CUR, DET_B[i_q[2:0]], '0);
							ph_q  <= 4'd1;
						end
						4'd1: begin cmd_q <= op(U_MUL); ph_q <= 4'd2; end
						4'd2: begin cmd_q <= op(U_RND); ph_q <= 4'd3; end
						4'd3: begin
							cmd_q <= mk(U_FETCH, SRC_P, '0, SRC_CUR, DET_C[i_q[2:0]], '0);
							ph_q  <= 4'd4;
						end
						4'd4: begin cmd_q <= op(U_MUL); ph_q <= 4'd5; end
						4'd5: begin cmd_q <= op(U_RND); ph_q <= 4'd6; end
						default: begin
							cmd_q <= op((i_q == 4'd0) ? U_LD : ((i_q < 4'd3) ? U_ADD : U_SUB));
							ph_q  <= '0;
							if (i_q == 4'd5) begin
								i_q     <= '0;
								state_q <= final_q ? S_DONE : S_SETD;
							end else begin
								i_q <= i_q + 4'd1;
							end
						end
					endcase
				end

				S_SETD: begin
					cmd_q   <= op(U_SET_D);
					state_q <= S_DWAIT;
				end

				S_DWAIT: state_q <= S_DCHK;

				// singular check
				S_DCHK: begin
					if (sts.d_zero) begin
						final_q <= 1'b1;
						i_q     <= '0;
						ph_q    <= '0;
						state_q <= S_DET;
					end else begin
						cmd_q   <= op(U_DIV_GO);
						state_q <= S_DIVW1;
					end
				end

				S_DIVW1: state_q <= S_DIVW;

				S_DIVW: begin
					if (!sts.div_busy) begin
						cmd_q   <= op(U_SET_REC);
						i_q     <= '0;
						ph_q    <= '0;
						state_q <= S_COF;
					end
				end

				// cofactor times reciprocal
				S_COF: begin
					case (ph_q)
						4'd0: begin
							cmd_q <= mk(U_FETCH, SRC_CUR, COF_A[i_q], SRC_CUR, COF_B[i_q], '0);
							ph_q  <= 4'd1;
						end
						4'd1:  begin cmd_q <= op(U_MUL); ph_q <= 4'd2; end
						4'd2:  begin cmd_q <= op(U_RND); ph_q <= 4'd3; end
						4'd3:  begin cmd_q <= op(U_LD);  ph_q <= 4'd4; end
						4'd4: begin
							cmd_q <= mk(U_FETCH, SRC_CUR, COF_C[i_q], SRC_CUR, COF_D[i_q], '0);
							ph_q  <= 4'd5;
						end
						4'd5:  begin cmd_q <= op(U_MUL); ph_q <= 4'd6; end
						4'd6:  begin cmd_q <= op(U_RND); ph_q <= 4'd7; end
						4'd7:  begin cmd_q <= op(U_SUB); ph_q <= 4'd8; end
						4'd8: begin
							cmd_q <= mk(U_FETCH, SRC_ACC, '0, SRC_REC, '0, '0);
							ph_q  <= 4'd9;
						end
						4'd9:  begin cmd_q <= op(U_MUL); ph_q <= 4'd10; end
						4'd10: begin cmd_q <= op(U_RND); ph_q <= 4'd11; end
						4'd11: begin cmd_q <= op(U_LD);  ph_q <= 4'd12; end
						default: begin
							cmd_q <= mk(U_WR_NM, SRC_ZERO, '0, SRC_ZERO, '0, COF_DST[i_q]);
							ph_q  <= '0;
							if (i_q == 4'd8) begin
								i_q     <= '0;
								state_q <= S_COPY;
							end else begin
								i_q <= i_q + 4'd1;
							end
						end
					endcase
				end

				S_DONE: begin
					cmd_q   <= op(U_DONE);
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// accept pulse rides with the registered command
	always_comb begin
		cmd      = cmd_q;
		cmd.load = start & ~busy_q;
	end

	assign busy = busy_q;

endmodule

FILE: rtl/matrix_transform_unit_core.sv
// ----------------------------------------------------------------------------
// matrix_transform_unit_core
// 4x4 homogeneous matrix transform unit in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears for exactly one cycle with done high, and the receiver cannot stall
// it, so sample the result ports whenever done is seen. All work runs through
// one shared 32x32 multiplier driven by a micro-sequencer, and every request
// ends with a determinant pass. A normal matrix request runs a first
// determinant pass, the reciprocal divider and the cofactors before that;
// a singular normal matrix skips the divider and the cofactors, and unused
// kinds run only the determinant pass. Reset leaves current as identity and
// staged as zero without any clearing pass.
// ----------------------------------------------------------------------------
module matrix_transform_unit_core import mtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] kind,
	input  logic [3:0] element_index,
	input  word_t      value,
	input  word_t      vec_x,
	input  word_t      vec_y,
	input  word_t      vec_z,
	input  word_t      vec_w,
	output logic       done,
	output word_t      out_x,
	output word_t      out_y,
	output word_t      out_z,
	output word_t      out_w,
	output word_t      determinant,
	output logic [1:0] status
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	mtu_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.element_index (element_index),
		.sts           (sts),
		.busy          (busy),
		.cmd           (cmd)
	);

	// arithmetic and storage
	mtu_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.vec_z       (vec_z),
		.vec_w       (vec_w),
		.sts         (sts),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.out_w       (out_w),
		.determinant (determinant),
		.status      (status),
		.done        (done)
	);

endmodule
